// ===== rtl/gpp_pkg.sv =====
package gpp_pkg;

    // Width of the pending_count result field
    localparam int PENDING_W = 5;

    // Input action codes
    localparam logic ACT_PARSE = 1'b0;
    localparam logic ACT_POP   = 1'b1;

    // Key packet finished by the parser on the current byte
    typedef struct packed {
        logic       complete;
        logic [7:0] x;
        logic [7:0] y;
        logic       pressed;
    } key_pkt_t;

endpackage

// ===== rtl/gpp_parser.sv =====
module gpp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [7:0]        rx_byte,
    output gpp_pkg::key_pkt_t pkt
);
    import gpp_pkg::*;

    // Parse phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_COLUMN = 2'd2;
    localparam logic [1:0] PH_ROW    = 2'd3;

    // Packet identifiers
    localparam logic [7:0] ID_SYS_QUERY  = 8'h00;
    localparam logic [7:0] ID_SYS_ID     = 8'h01;
    localparam logic [7:0] ID_SYS_OFFSET = 8'h02;
    localparam logic [7:0] ID_SYS_SIZE   = 8'h03;
    localparam logic [7:0] ID_SYS_ADDR   = 8'h04;
    localparam logic [7:0] ID_SYS_VER    = 8'h0F;
    localparam logic [7:0] ID_KEY_UP     = 8'h20;
    localparam logic [7:0] ID_KEY_DOWN   = 8'h21;
    localparam logic [7:0] ID_TILT_ACT   = 8'h50;
    localparam logic [7:0] ID_TILT_ON    = 8'h51;
    localparam logic [7:0] ID_TILT_OFF   = 8'h52;

    // Payload bytes that follow each identifier
    function automatic logic [5:0] payload_length(input logic [7:0] id);
        case (id)
            ID_SYS_QUERY:  payload_length = 6'd2;
            ID_SYS_ID:     payload_length = 6'd32;
            ID_SYS_OFFSET: payload_length = 6'd3;
            ID_SYS_SIZE:   payload_length = 6'd2;
            ID_SYS_ADDR:   payload_length = 6'd2;
            ID_SYS_VER:    payload_length = 6'd8;
            ID_KEY_UP:     payload_length = 6'd2;
            ID_KEY_DOWN:   payload_length = 6'd2;
            ID_TILT_ACT:   payload_length = 6'd2;
            ID_TILT_ON:    payload_length = 6'd1;
            ID_TILT_OFF:   payload_length = 6'd1;
            default:       payload_length = 6'd0;
        endcase
    endfunction

    logic [1:0] phase_reg, phase_next;
    logic [5:0] bytes_left_reg, bytes_left_next;
    logic       pressed_reg, pressed_next;
    logic [7:0] column_reg, column_next;
    logic [5:0] bytes_dec;
    logic [5:0] id_len;

    assign bytes_dec = (bytes_left_reg != 6'd0) ? bytes_left_reg - 6'd1 : 6'd0;
    assign id_len    = payload_length(rx_byte);

    // Phase sequencing, one byte per enable
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        pressed_next    = pressed_reg;
        column_next     = column_reg;
        if (byte_en)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == ID_KEY_UP || rx_byte == ID_KEY_DOWN)
                    begin
                        pressed_next    = rx_byte[0];
                        phase_next      = PH_COLUMN;
                        bytes_left_next = 6'd2;
                    end
                    else
                    begin
                        bytes_left_next = id_len;
                        phase_next      = (id_len != 6'd0) ? PH_SKIP : PH_IDLE;
                    end
                end
                PH_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 6'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_COLUMN:
                begin
                    column_next     = rx_byte;
                    bytes_left_next = 6'd1;
                    phase_next      = PH_ROW;
                end
                default:
                begin
                    bytes_left_next = 6'd0;
                    phase_next      = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= 6'd0;
            pressed_reg    <= 1'b0;
            column_reg     <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            pressed_reg    <= pressed_next;
            column_reg     <= column_next;
        end
    end

    // Row byte finishes a key packet
    always_comb
    begin
        pkt.complete = byte_en && (phase_reg == PH_ROW);
        pkt.x        = column_reg;
        pkt.y        = rx_byte;
        pkt.pressed  = pressed_reg;
    end

endmodule

// ===== rtl/grid_packet_parser_event_fifo.sv =====
// Grid link packet parser with a key event FIFO. Each input item is either a
// received link byte (action 0) or a pop request (action 1); every item yields
// exactly one result, registered and presented in the cycle after acceptance.
// One item is taken per clock: in_ready is high whenever the output register
// is empty or its result is taken in the same cycle, so the rate is set by the
// single output register and the one-read, one-write event memory. Key up and
// key down packets queue (x, y, pressed) into a ring of QUEUE_DEPTH entries;
// when the ring is full the event is lost and event_dropped flags it. A pop on
// an empty ring returns all-zero key fields with event_valid low.
// pending_count is the low five bits of the event count, exact for depths
// up to 31. There is no clearing pass after reset.
module grid_packet_parser_event_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          event_valid,
    output logic [7:0]                    key_x,
    output logic [7:0]                    key_y,
    output logic                          key_pressed,
    output logic [gpp_pkg::PENDING_W-1:0] pending_count,
    output logic                          event_dropped
);
    import gpp_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] IDX_ONE   = IW'(1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    logic           accept;
    logic           pop_hit;
    logic           push_ok;
    logic           full;
    key_pkt_t       pkt;

    logic [IW-1:0]  head_reg, head_next;
    logic [IW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW+PENDING_W-1:0] count_ext;

    logic           out_valid_reg;
    logic           event_valid_reg;
    logic [7:0]     key_x_reg;
    logic [7:0]     key_y_reg;
    logic           key_pressed_reg;
    logic [PENDING_W-1:0] pending_reg;
    logic           dropped_reg;

    // Event store: {x, y, pressed}
    logic [16:0]    mem [QUEUE_DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == FULL_CNT);
    assign pop_hit  = accept && (action == ACT_POP) && (count_reg != '0);
    assign push_ok  = pkt.complete && !full;

    gpp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (accept && (action == ACT_PARSE)),
        .rx_byte (rx_byte),
        .pkt     (pkt)
    );

    // Ring pointers and fill count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop_hit)
        begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + IDX_ONE;
            count_next = count_reg - CNT_ONE;
        end
        else if (push_ok)
        begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + IDX_ONE;
            count_next = count_reg + CNT_ONE;
        end
    end

    assign count_ext = {{PENDING_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Memory write
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= {pkt.x, pkt.y, pkt.pressed};
        end
    end

    // Result register, memory read data lands here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_valid_reg <= pop_hit;
            pending_reg     <= count_ext[PENDING_W-1:0];
            dropped_reg     <= pkt.complete && full;
            if (pop_hit)
            begin
                {key_x_reg, key_y_reg, key_pressed_reg} <= mem[head_reg];
            end
            else
            begin
                key_x_reg       <= 8'd0;
                key_y_reg       <= 8'd0;
                key_pressed_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_valid   = event_valid_reg;
    assign key_x         = key_x_reg;
    assign key_y         = key_y_reg;
    assign key_pressed   = key_pressed_reg;
    assign pending_count = pending_reg;
    assign event_dropped = dropped_reg;

endmodule

// ===== rtl/gpp_checker.sv =====
module gpp_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          action,
    input logic [7:0]                    rx_byte,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          event_valid,
    input logic [7:0]                    key_x,
    input logic [7:0]                    key_y,
    input logic                          key_pressed,
    input logic [gpp_pkg::PENDING_W-1:0] pending_count,
    input logic                          event_dropped
);
    import gpp_pkg::*;

    localparam bit EXACT_CNT = (QUEUE_DEPTH < 32);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_valid)
            && $stable(key_x) && $stable(key_y) && $stable(key_pressed)
            && $stable(pending_count) && $stable(event_dropped))
        else $error("result changed while stalled");

    // Key fields are zero unless a stored event was popped
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> key_x == 8'd0 && key_y == 8'd0 && !key_pressed)
        else $error("key fields set without a popped event");

    // A pop and a drop never share a result
    a_pop_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(event_valid && event_dropped))
        else $error("popped and dropped in one result");

    // A drop only happens with the queue full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_dropped && EXACT_CNT |->
            pending_count == PENDING_W'(QUEUE_DEPTH))
        else $error("event dropped while queue not full");

endmodule

bind grid_packet_parser_event_fifo gpp_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_gpp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gpp_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int DRAIN_CYCLES   = 10;

    // Packet identifiers
    localparam logic [7:0] ID_CFG_A     = 8'h00;
    localparam logic [7:0] ID_LED_FRAME = 8'h01;
    localparam logic [7:0] ID_CFG_B     = 8'h02;
    localparam logic [7:0] ID_CFG_C     = 8'h03;
    localparam logic [7:0] ID_CFG_D     = 8'h04;
    localparam logic [7:0] ID_CFG_E     = 8'h0F;
    localparam logic [7:0] ID_KEY_UP    = 8'h20;
    localparam logic [7:0] ID_KEY_DOWN  = 8'h21;
    localparam logic [7:0] ID_TILT_A    = 8'h50;
    localparam logic [7:0] ID_TILT_B    = 8'h51;
    localparam logic [7:0] ID_TILT_C    = 8'h52;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_SKIP,
        PARSE_COLUMN,
        PARSE_ROW
    } parse_state_t;

    typedef struct packed {
        logic                 event_valid;
        logic [7:0]           key_x;
        logic [7:0]           key_y;
        logic                 key_pressed;
        logic [PENDING_W-1:0] pending_count;
        logic                 event_dropped;
    } key_result_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       pressed;
    } key_entry_t;

    typedef struct packed {
        logic        act;
        logic [7:0]  data;
        logic        has_fix;
        key_result_t fix;
    } stim_row_t;

    localparam key_result_t NO_FIX = '0;

    // Directed items; fixed results only where obvious
    localparam int N_DIRECTED = 22;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // pop right after reset: empty
        '{ACT_POP,   8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0}},
        // key down at extreme corner (0, 255)
        '{ACT_PARSE, 8'h21, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0}},
        '{ACT_PARSE, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0}},
        '{ACT_PARSE, 8'hFF, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd1, 1'b0}},
        // key up at (255, 0)
        '{ACT_PARSE, 8'h20, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd1, 1'b0}},
        '{ACT_PARSE, 8'hFF, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd1, 1'b0}},
        '{ACT_PARSE, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 5'd2, 1'b0}},
        '{ACT_POP,   8'hFF, 1'b1, '{1'b1, 8'h00, 8'hFF, 1'b1, 5'd1, 1'b0}},
        // pop in the middle of a key packet
        '{ACT_PARSE, 8'h20, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h05, 1'b0, NO_FIX},
        '{ACT_POP,   8'h00, 1'b1, '{1'b1, 8'hFF, 8'h00, 1'b0, 5'd0, 1'b0}},
        '{ACT_PARSE, 8'h07, 1'b0, NO_FIX},
        // key ids inside payloads are skipped
        '{ACT_PARSE, 8'h51, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h20, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h00, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h21, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h21, 1'b0, NO_FIX},
        // unknown id, no payload
        '{ACT_PARSE, 8'hFF, 1'b0, NO_FIX},
        '{ACT_POP,   8'h5A, 1'b0, NO_FIX},
        '{ACT_POP,   8'hA5, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h52, 1'b0, NO_FIX},
        '{ACT_PARSE, 8'h80, 1'b0, NO_FIX}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 event_valid;
    logic [7:0]           key_x;
    logic [7:0]           key_y;
    logic                 key_pressed;
    logic [PENDING_W-1:0] pending_count;
    logic                 event_dropped;

    // Predictor state
    parse_state_t parse_st;
    int           skip_left;
    logic         key_down;
    logic [7:0]   col_hold;
    key_entry_t   ev_store [QDEPTH];
    int           ev_head;
    int           ev_count;

    key_result_t  expected_q [$];
    stim_row_t    fixed_q [$];
    stim_row_t    random_q [$];
    int           err_count;
    int           idle_cycles;
    bit           no_idle;
    bit           hold_req;
    key_result_t  got_res;
    key_result_t  want_res;
    stim_row_t    acc_row;

    grid_packet_parser_event_fifo #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_valid  (event_valid),
        .key_x        (key_x),
        .key_y        (key_y),
        .key_pressed  (key_pressed),
        .pending_count(pending_count),
        .event_dropped(event_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Payload bytes that follow each identifier
    function automatic int payload_len(input logic [7:0] id);
        case (id)
            ID_CFG_A:     return 2;
            ID_LED_FRAME: return 32;
            ID_CFG_B:     return 3;
            ID_CFG_C:     return 2;
            ID_CFG_D:     return 2;
            ID_CFG_E:     return 8;
            ID_KEY_UP:    return 2;
            ID_KEY_DOWN:  return 2;
            ID_TILT_A:    return 2;
            ID_TILT_B:    return 1;
            ID_TILT_C:    return 1;
            default:      return 0;
        endcase
    endfunction

    // Advance the parser/queue model by one item and return its result
    function automatic key_result_t parse_and_queue(input logic act, input logic [7:0] b);
        key_result_t r;
        int          slot;
        r = '0;
        if (act == ACT_POP)
        begin
            if (ev_count > 0)
            begin
                r.event_valid = 1'b1;
                r.key_x       = ev_store[ev_head].x;
                r.key_y       = ev_store[ev_head].y;
                r.key_pressed = ev_store[ev_head].pressed;
                ev_head       = (ev_head + 1) % QDEPTH;
                ev_count      = ev_count - 1;
            end
        end
        else
        begin
            case (parse_st)
                PARSE_IDLE:
                begin
                    if (b == ID_KEY_UP || b == ID_KEY_DOWN)
                    begin
                        key_down  = b[0];
                        parse_st  = PARSE_COLUMN;
                        skip_left = 2;
                    end
                    else
                    begin
                        skip_left = payload_len(b);
                        parse_st  = (skip_left != 0) ? PARSE_SKIP : PARSE_IDLE;
                    end
                end
                PARSE_SKIP:
                begin
                    if (skip_left > 0)
                        skip_left = skip_left - 1;
                    if (skip_left == 0)
                        parse_st = PARSE_IDLE;
                end
                PARSE_COLUMN:
                begin
                    col_hold  = b;
                    skip_left = 1;
                    parse_st  = PARSE_ROW;
                end
                default:
                begin
                    if (ev_count >= QDEPTH)
                    begin
                        r.event_dropped = 1'b1;
                    end
                    else
                    begin
                        slot = (ev_head + ev_count) % QDEPTH;
                        ev_store[slot].x       = col_hold;
                        ev_store[slot].y       = b;
                        ev_store[slot].pressed = key_down;
                        ev_count = ev_count + 1;
                    end
                    skip_left = 0;
                    parse_st  = PARSE_IDLE;
                end
            endcase
        end
        r.pending_count = PENDING_W'(ev_count);
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 99)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Coordinates biased toward the extremes
    function automatic logic [7:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        else if (r < 30)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ID_KEY_UP;
        else if (r == 1)
            return ID_KEY_DOWN;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic stim_row_t mk_row(input logic act, input logic [7:0] b);
        stim_row_t r;
        r         = '0;
        r.act     = act;
        r.data    = b;
        r.has_fix = 1'b0;
        return r;
    endfunction

    // Random stream: phases that fill, balance or drain the queue
    task automatic build_random();
        logic [7:0] other_ids [10];
        logic [7:0] id;
        int         phase_left;
        int         pop_pct;
        int         kind;
        int         len;
        bit         mid_pop;
        other_ids  = '{ID_CFG_A, ID_LED_FRAME, ID_CFG_B, ID_CFG_C, ID_CFG_D,
                       ID_CFG_E, ID_TILT_A, ID_TILT_B, ID_TILT_C, 8'h7E};
        phase_left = 0;
        pop_pct    = 20;
        while (random_q.size() < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       pop_pct = 3;
                    1:       pop_pct = 20;
                    default: pop_pct = 55;
                endcase
                phase_left = $urandom_range(40, 150);
            end
            phase_left = phase_left - 1;
            if ($urandom_range(0, 99) < pop_pct)
            begin
                random_q.push_back(mk_row(ACT_POP, 8'($urandom_range(0, 255))));
            end
            else
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    // well-formed key packet, sometimes with a pop inside
                    mid_pop = ($urandom_range(0, 99) < 15);
                    id = $urandom_range(0, 1) ? ID_KEY_DOWN : ID_KEY_UP;
                    random_q.push_back(mk_row(ACT_PARSE, id));
                    if (mid_pop && $urandom_range(0, 1))
                        random_q.push_back(mk_row(ACT_POP, 8'($urandom_range(0, 255))));
                    random_q.push_back(mk_row(ACT_PARSE, pick_coord()));
                    if (mid_pop && $urandom_range(0, 1))
                        random_q.push_back(mk_row(ACT_POP, 8'($urandom_range(0, 255))));
                    random_q.push_back(mk_row(ACT_PARSE, pick_coord()));
                end
                else if (kind < 8)
                begin
                    // other packet with its full payload
                    id = other_ids[$urandom_range(0, 9)];
                    if (id == ID_LED_FRAME && $urandom_range(0, 3) != 0)
                        id = ID_TILT_B;
                    random_q.push_back(mk_row(ACT_PARSE, id));
                    len = payload_len(id);
                    for (int k = 0; k < len; k++)
                        random_q.push_back(mk_row(ACT_PARSE, pick_payload()));
                end
                else if (kind == 8)
                begin
                    // noise byte
                    random_q.push_back(mk_row(ACT_PARSE, 8'($urandom_range(0, 255))));
                end
                else
                begin
                    // broken packet: identifier followed by a pop
                    random_q.push_back(mk_row(ACT_PARSE, other_ids[$urandom_range(0, 9)]));
                    random_q.push_back(mk_row(ACT_POP, 8'($urandom_range(0, 255))));
                end
            end
        end
    endtask

    // Offer one item and hold it until accepted; called at a falling edge
    task automatic offer_item(input stim_row_t r);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= r.act;
        rx_byte  <= r.data;
        fixed_q.push_back(r);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                gap = no_idle ? 0 : pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // Result check, prediction on acceptance, and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_res = '{event_valid, key_x, key_y, key_pressed, pending_count,
                            event_dropped};
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result v=%0d x=%02h y=%02h p=%0d n=%0d d=%0d",
                             $realtime, got_res.event_valid, got_res.key_x, got_res.key_y,
                             got_res.key_pressed, got_res.pending_count,
                             got_res.event_dropped);
                end
                else
                begin
                    want_res = expected_q.pop_front();
                    if (got_res !== want_res)
                    begin
                        err_count++;
                        $write("%0t: mismatch exp v=%0d x=%02h y=%02h p=%0d n=%0d d=%0d",
                               $realtime, want_res.event_valid, want_res.key_x,
                               want_res.key_y, want_res.key_pressed,
                               want_res.pending_count, want_res.event_dropped);
                        $display(" got v=%0d x=%02h y=%02h p=%0d n=%0d d=%0d",
                                 got_res.event_valid, got_res.key_x, got_res.key_y,
                                 got_res.key_pressed, got_res.pending_count,
                                 got_res.event_dropped);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                acc_row  = fixed_q.pop_front();
                want_res = parse_and_queue(action, rx_byte);
                expected_q.push_back(acc_row.has_fix ? acc_row.fix : want_res);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        int hold_at;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_PARSE;
        rx_byte     = 8'h00;
        err_count   = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        parse_st    = PARSE_IDLE;
        skip_left   = 0;
        key_down    = 1'b0;
        col_hold    = 8'h00;
        ev_head     = 0;
        ev_count    = 0;
        for (int k = 0; k < QDEPTH; k++)
            ev_store[k] = '0;
        build_random();
        hold_at = $urandom_range(200, 600);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer_item(DIRECTED[i]);

        // Random stream
        for (int i = 0; i < random_q.size(); i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i == hold_at)
                hold_req = 1'b1;
            offer_item(random_q[i]);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_q.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d results never arrived", $realtime, expected_q.size());
        end
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
